// File: src/rgb_kernel_convolution_filter_core_assert.svh
// Assertion macros for the convolution core
`ifndef RGB_KERNEL_CONVOLUTION_FILTER_CORE_ASSERT_SVH
`define RGB_KERNEL_CONVOLUTION_FILTER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RKC_ASSERT_IMPL(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RKC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) else $error(msg);
`else
`define RKC_ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define RKC_ASSERT_NEXT(label, clk, rst_n, cond, conseq, msg)
`endif
`endif

// File: src/rkc_pkg.sv
`timescale 1ns / 1ps
package rkc_pkg;
	// line counters hold up to the maximum height
	localparam int LW = 13;
	localparam int HMAX = 4096;
	localparam int SW = 21;
	localparam int TW = 48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_WAIT,
		ST_MUL,
		ST_RND,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		REG_KROW0 = 3'd0,
		REG_KROW1 = 3'd1,
		REG_KROW2 = 3'd2,
		REG_RECIP = 3'd3,
		REG_OFFSET = 3'd4,
		REG_WIDTH = 3'd5,
		REG_HEIGHT = 3'd6
	} reg_idx_t;
endpackage

// File: src/rgb_kernel_convolution_filter_core.sv
`timescale 1ns / 1ps
// Input: a word that is due a result stalls the input until that result is loaded
// into the output register; the computation is paced by the single read port of
// the line store (one window tap per cycle) and may be held by out_stall. A word
// that gives no result is taken every cycle while the core is idle.
// Reset: asynchronous, clears control state and loads register defaults; the
// line store is not cleared.
`include "rgb_kernel_convolution_filter_core_assert.svh"
module rgb_kernel_convolution_filter_core #(
	parameter int KSIZE = 3,
	parameter int MAX_WIDTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        cmd,
	input  logic [7:0]  in_red,
	input  logic [7:0]  in_green,
	input  logic [7:0]  in_blue,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_red,
	output logic [7:0]  out_green,
	output logic [7:0]  out_blue,
	output logic        last_of_frame,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam int HALF = KSIZE / 2;
	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int AW = CW + 2;
	localparam int DEPTH = 4 << CW;
	localparam int LW = rkc_pkg::LW;
	localparam int SW = rkc_pkg::SW;
	localparam int TW = rkc_pkg::TW;

	rkc_pkg::state_t state_q, state_d;

	logic [23:0] krow_q [3];
	logic signed [23:0] recip_q;
	logic signed [8:0] offset_q;
	logic [10:0] width_q;
	logic [12:0] height_q;

	logic [CW-1:0] icol_q, ocol_q, pcol_q;
	logic [LW-1:0] iline_q, oline_q, pline_q;
	logic plast_q;

	logic [23:0] mem [DEPTH];
	logic [AW-1:0] raddr;
	logic [23:0] rdata_s1;
	logic rvalid_s1;
	logic [1:0] kr_q, kc_q, kr_s1, kc_s1;
	logic [1:0] ch_q;

	logic signed [SW-1:0] sum_q [3];
	logic signed [SW+24:0] prod_s1;
	logic pv_s1;
	logic [1:0] pch_s1;
	logic [7:0] res_q [3];

	logic ov_q;
	logic [7:0] ored_q, ogrn_q, oblu_q;
	logic olast_q;

	// effective geometry
	logic [WW-1:0] weff;
	logic [LW-1:0] heff;
	always_comb begin
		if (width_q == 11'd0) weff = WW'(1);
		else if (32'(width_q) > MAX_WIDTH) weff = WW'(MAX_WIDTH);
		else weff = WW'(width_q);
		if (height_q == 13'd0) heff = LW'(1);
		else if (height_q > 13'(rkc_pkg::HMAX)) heff = LW'(rkc_pkg::HMAX);
		else heff = height_q;
	end

	logic in_acc, out_acc;
	assign in_acc = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;
	assign in_stall = (state_q != rkc_pkg::ST_IDLE);

	// work out the positions this word sees and whether it emits
	logic restart;
	logic [CW-1:0] icol_e, ocol_e, icol_n, ocol_n;
	logic [LW-1:0] iline_e, oline_e, iline_n, oline_n;
	logic emit, last_e;
	always_comb begin
		restart = !cmd && (iline_q >= heff);
		icol_e = restart ? '0 : icol_q;
		iline_e = restart ? '0 : iline_q;
		ocol_e = restart ? '0 : ocol_q;
		oline_e = restart ? '0 : oline_q;
		if (!cmd) begin
			emit = ((iline_e > LW'(HALF)) ||
				(iline_e == LW'(HALF) && icol_e >= CW'(HALF))) && (oline_e < heff);
		end else begin
			emit = (iline_q >= heff) && (oline_q < heff);
		end
		icol_n = icol_e;
		iline_n = iline_e;
		if (!cmd) begin
			if ((WW'(icol_e) + WW'(1)) >= weff) begin
				icol_n = '0;
				iline_n = iline_e + LW'(1);
			end else begin
				icol_n = icol_e + CW'(1);
			end
		end
		ocol_n = ocol_e;
		oline_n = oline_e;
		last_e = (WW'(ocol_e) == weff - WW'(1)) && (oline_e == heff - LW'(1));
		if (emit) begin
			if ((WW'(ocol_e) + WW'(1)) >= weff) begin
				ocol_n = '0;
				oline_n = oline_e + LW'(1);
			end else begin
				ocol_n = ocol_e + CW'(1);
			end
		end
	end

	// configuration registers and raster positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			krow_q[0] <= 24'd0;
			krow_q[1] <= 24'd256;
			krow_q[2] <= 24'd0;
			recip_q <= 24'sd65536;
			offset_q <= '0;
			width_q <= 11'd1024;
			height_q <= 13'd768;
			icol_q <= '0;
			iline_q <= '0;
			ocol_q <= '0;
			oline_q <= '0;
		end else begin
			if (in_acc) begin
				icol_q <= icol_n;
				iline_q <= iline_n;
				ocol_q <= ocol_n;
				oline_q <= oline_n;
			end
			if (cfg_we) begin
				case (rkc_pkg::reg_idx_t'(cfg_index))
					rkc_pkg::REG_KROW0: krow_q[0] <= cfg_data;
					rkc_pkg::REG_KROW1: krow_q[1] <= cfg_data;
					rkc_pkg::REG_KROW2: krow_q[2] <= cfg_data;
					rkc_pkg::REG_RECIP: recip_q <= cfg_data;
					rkc_pkg::REG_OFFSET: offset_q <= cfg_data[8:0];
					rkc_pkg::REG_WIDTH: begin
						width_q <= cfg_data[10:0];
						icol_q <= '0;
						iline_q <= '0;
						ocol_q <= '0;
						oline_q <= '0;
					end
					rkc_pkg::REG_HEIGHT: begin
						height_q <= cfg_data[12:0];
						icol_q <= '0;
						iline_q <= '0;
						ocol_q <= '0;
						oline_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// hold the output position of the word being computed
	always_ff @(posedge clk) begin
		if (in_acc && emit) begin
			pcol_q <= ocol_e;
			pline_q <= oline_e;
			plast_q <= last_e;
		end
	end

	// window tap address with clamp to edge
	logic signed [LW+1:0] rowv, colv;
	logic [LW-1:0] rowc;
	logic [CW-1:0] colc;
	always_comb begin
		rowv = $signed({2'b00, pline_q}) + (LW+2)'(HALF) - $signed({{LW{1'b0}}, kr_q});
		colv = $signed({{(LW+2-CW){1'b0}}, pcol_q}) - (LW+2)'(HALF)
			+ $signed({{LW{1'b0}}, kc_q});
		if (rowv < 0) rowc = '0;
		else if (rowv > $signed({2'b00, heff - LW'(1)})) rowc = heff - LW'(1);
		else rowc = rowv[LW-1:0];
		if (colv < 0) colc = '0;
		else if (colv > $signed((LW+2)'(weff - WW'(1)))) colc = CW'(weff - WW'(1));
		else colc = colv[CW-1:0];
		raddr = {rowc[1:0], colc};
	end

	// line store: write incoming pixel, read one tap a cycle
	always_ff @(posedge clk) begin
		if (in_acc && !cmd) begin
			mem[{iline_e[1:0], icol_e}] <= {in_blue, in_green, in_red};
		end
		rdata_s1 <= mem[raddr];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= rkc_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			rkc_pkg::ST_IDLE: if (in_acc && emit) state_d = rkc_pkg::ST_READ;
			rkc_pkg::ST_READ: begin
				if (kr_q == 2'(KSIZE - 1) && kc_q == 2'(KSIZE - 1)) state_d = rkc_pkg::ST_WAIT;
			end
			rkc_pkg::ST_WAIT: state_d = rkc_pkg::ST_MUL;
			rkc_pkg::ST_MUL: if (ch_q == 2'd2) state_d = rkc_pkg::ST_RND;
			rkc_pkg::ST_RND: state_d = rkc_pkg::ST_OUT;
			rkc_pkg::ST_OUT: if (!ov_q || !out_stall) state_d = rkc_pkg::ST_IDLE;
			default: state_d = rkc_pkg::ST_IDLE;
		endcase
	end

	// advance tap and channel counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kr_q <= '0;
			kc_q <= '0;
			ch_q <= '0;
			rvalid_s1 <= 1'b0;
			pv_s1 <= 1'b0;
		end else begin
			rvalid_s1 <= (state_q == rkc_pkg::ST_READ);
			pv_s1 <= (state_q == rkc_pkg::ST_MUL);
			if (state_q == rkc_pkg::ST_IDLE) begin
				kr_q <= '0;
				kc_q <= '0;
				ch_q <= '0;
			end else if (state_q == rkc_pkg::ST_READ) begin
				if (kc_q == 2'(KSIZE - 1)) begin
					kc_q <= '0;
					kr_q <= kr_q + 2'd1;
				end else begin
					kc_q <= kc_q + 2'd1;
				end
			end else if (state_q == rkc_pkg::ST_MUL) begin
				ch_q <= ch_q + 2'd1;
			end
		end
	end

	// accumulate the window per channel
	logic [7:0] coef;
	always_comb coef = krow_q[kr_s1][{kc_s1, 3'b000} +: 8];

	always_ff @(posedge clk) begin
		kr_s1 <= kr_q;
		kc_s1 <= kc_q;
		if (state_q == rkc_pkg::ST_IDLE) begin
			for (int c = 0; c < 3; c++) sum_q[c] <= '0;
		end else if (rvalid_s1) begin
			for (int c = 0; c < 3; c++) begin
				sum_q[c] <= sum_q[c] + SW'($signed({1'b0, rdata_s1[8*c +: 8]})
					* $signed(coef));
			end
		end
	end

	// scale one channel a cycle
	always_ff @(posedge clk) begin
		prod_s1 <= (SW+25)'(sum_q[ch_q]) * (SW+25)'(recip_q);
		pch_s1 <= ch_q;
	end

	// round half away from zero and saturate
	logic signed [TW-1:0] tsum, tround;
	logic [7:0] rsat;
	always_comb begin
		tsum = TW'(prod_s1) + (TW'(offset_q) <<< 16);
		tround = tsum + TW'(32768);
		if (tsum[TW-1]) rsat = 8'd0;
		else if ((tround >>> 16) > TW'(255)) rsat = 8'd255;
		else rsat = tround[23:16];
	end

	always_ff @(posedge clk) begin
		if (pv_s1) res_q[pch_s1] <= rsat;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (state_q == rkc_pkg::ST_OUT && (!ov_q || !out_stall)) begin
			ov_q <= 1'b1;
		end else if (out_acc) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == rkc_pkg::ST_OUT && (!ov_q || !out_stall)) begin
			ored_q <= res_q[0];
			ogrn_q <= res_q[1];
			oblu_q <= res_q[2];
			olast_q <= plast_q;
		end
	end

	assign out_valid = ov_q;
	assign out_red = ored_q;
	assign out_green = ogrn_q;
	assign out_blue = oblu_q;
	assign last_of_frame = olast_q;

	`RKC_ASSERT_IMPL(a_busy_stalls, clk, arst_n, (state_q != rkc_pkg::ST_IDLE) |-> in_stall, "input taken while busy")
	`RKC_ASSERT_NEXT(a_out_from_fsm, clk, arst_n, (state_q == rkc_pkg::ST_IDLE && !ov_q), !ov_q, "output without compute")
	`RKC_ASSERT_NEXT(a_mul_follows_wait, clk, arst_n, (state_q == rkc_pkg::ST_WAIT), (state_q == rkc_pkg::ST_MUL && ch_q == 2'd0), "multiply out of order")
endmodule
